>>> rtl/mlfq_pkg.sv
// Shared types and constants of the two-level feedback queue scheduler.
`default_nettype none
package mlfq_pkg;
   localparam int SLOTS = 64;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [2:0] {
      F_CREATE  = 3'd0,
      F_SCHED   = 3'd1,
      F_TICK    = 3'd2,
      F_SETPRIO = 3'd3,
      F_YIELD   = 3'd4,
      F_SLEEP   = 3'd5,
      F_WAKE    = 3'd6,
      F_RELEASE = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      RS_OK     = 2'd0,
      RS_NOFREE = 2'd1,
      RS_NOPID  = 2'd2,
      RS_NORUN  = 2'd3
   } rstat_type;

   typedef enum logic [1:0] {
      SS_UNUSED   = 2'd0,
      SS_RUNNABLE = 2'd1,
      SS_RUNNING  = 2'd2,
      SS_SLEEPING = 2'd3
   } sstat_type;

   typedef enum logic [1:0] {
      CSR_BOOST = 2'd0,
      CSR_Q0    = 2'd1,
      CSR_Q1    = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SCAN, B_DECIDE, B_READ, B_EXEC
   } bstate_type;

   typedef struct packed {
      func_type    func;
      logic [5:0]  slot;
      logic [15:0] tpid;
      logic [7:0]  npri;
      logic [15:0] chan;
      logic        scan;
   } op_type;

   typedef struct packed {
      logic [15:0] chan;
      logic [3:0]  ticks;
      logic [7:0]  prio;
      logic        level;
      logic [15:0] pid;
      sstat_type   st;
   } entry_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } qout_type;
endpackage
`default_nettype wire

>>> rtl/mlfq_front.sv
// Front end: accepts requests, marks those that need a table scan, queues two.
`default_nettype none
module mlfq_front import mlfq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // slot, target_pid, new_priority, channel, pad
   input  wire logic [2:0]  req_tuser,  // func
   output qout_type         q_out,
   input  wire logic        q_pop
);
   op_type     q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   op_type     op_in;
   logic       push;

   always_comb begin
      op_in.func = func_type'(req_tuser);
      op_in.slot = req_tdata[5:0];
      op_in.tpid = req_tdata[21:6];
      op_in.npri = req_tdata[29:22];
      op_in.chan = req_tdata[45:30];
      case (op_in.func)
         F_CREATE, F_SCHED, F_SETPRIO, F_WAKE: op_in.scan = 1'b1;
         default:                              op_in.scan = 1'b0;
      endcase
   end

   assign req_tready  = (cnt_ff != 2'd2);
   assign push        = req_tvalid && req_tready;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.op    = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= op_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop && q_out.valid) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop && q_out.valid);
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
endmodule
`default_nettype wire

>>> rtl/mlfq_back.sv
// Back end: slot table memory, scan sequencer and operation execution.
`default_nettype none
module mlfq_back import mlfq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qout_type    q_in,
   output logic             q_pop,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // chosen_slot, chosen_pid, chosen_level, preempted
   output logic [1:0]       rsp_tuser   // status
);
   entry_type mem [SLOTS];
   entry_type rdata_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [SLOTS-1:0] vld_ff, sch_ff;
   bstate_type st_ff, st_in;
   op_type cur_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic dv_ff;
   logic [IDX_W-1:0] didx_ff, tgt_ff;
   logic hit_ff, any_ff, best_ff, ok_ff;
   logic [IDX_W-1:0] hit_idx_ff, any_idx_ff, best_idx_ff;
   logic [7:0]  best_pri_ff;
   logic [15:0] best_pid_ff, pid_ctr_ff;
   logic [7:0]  boost_cnt_ff, boost_per_ff;
   logic [3:0]  q0_ff, q1_ff;
   logic [CNT_W-1:0] cursor_ff;
   logic found_ff;
   logic rsp_valid_ff;
   rstat_type rs_ff;
   logic [5:0]  rslot_ff;
   logic [15:0] rpid_ff;
   logic rlvl_ff, rpre_ff;

   entry_type e, wdata;
   logic [IDX_W-1:0] e_idx, waddr;
   logic we, rsp_free, fire, do_boost, run, pre, clr_vld;
   logic [7:0] boost_nx;
   logic [3:0] tk;
   rstat_type rs_c;
   logic [15:0] rpid_c;
   logic rlvl_c;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign fire     = (st_ff == B_EXEC) && rsp_free;
   assign rd_addr  = (st_ff == B_SCAN) ? cnt_ff[IDX_W-1:0] : tgt_ff;
   assign e_idx    = (st_ff == B_EXEC) ? tgt_ff : didx_ff;
   assign q_pop    = (st_ff == B_IDLE);

   // Entries never written read as reset values through the valid bits.
   always_comb begin
      e = rdata_ff;
      if (!vld_ff[e_idx]) begin
         e.st  = SS_UNUSED;
         e.pid = 16'd0;
      end
      if (!sch_ff[e_idx]) begin
         e.level = 1'b0;
         e.prio  = 8'd0;
         e.ticks = 4'd0;
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         B_IDLE:   if (q_in.valid) st_in = q_in.op.scan ? B_SCAN : B_READ;
         B_SCAN:   if (cnt_ff == CNT_W'(SLOTS) && !dv_ff) st_in = B_DECIDE;
         B_DECIDE: st_in = B_READ;
         B_READ:   st_in = B_EXEC;
         B_EXEC:   if (rsp_free) st_in = B_IDLE;
         default:  st_in = B_IDLE;
      endcase
   end

   // Wake writes during the scan, execution of the addressed entry and the result fields.
   always_comb begin
      we = 1'b0; waddr = tgt_ff; wdata = e; clr_vld = 1'b0;
      rs_c = RS_OK; rpid_c = 16'd0; rlvl_c = 1'b0;
      do_boost = 1'b0; run = 1'b0; pre = 1'b0;
      boost_nx = boost_cnt_ff + 8'd1;
      tk = (e.ticks == 4'd15) ? 4'd15 : e.ticks + 4'd1;
      if (st_ff == B_SCAN) begin
         if (dv_ff && cur_ff.func == F_WAKE && e.st == SS_SLEEPING &&
             e.chan == cur_ff.chan) begin
            we = 1'b1; waddr = didx_ff; wdata.st = SS_RUNNABLE;
         end
      end else if (fire) begin
         case (cur_ff.func)
            F_CREATE: begin
               if (ok_ff) begin
                  we = 1'b1;
                  wdata.st = SS_RUNNABLE; wdata.pid = pid_ctr_ff;
                  wdata.level = 1'b0; wdata.prio = 8'd0; wdata.ticks = 4'd0;
                  rpid_c = pid_ctr_ff;
               end else rs_c = RS_NOFREE;
            end
            F_SCHED: begin
               if (ok_ff) begin
                  we = 1'b1; wdata.st = SS_RUNNING;
                  rpid_c = e.pid; rlvl_c = e.level;
               end else rs_c = RS_NORUN;
            end
            F_TICK: begin
               run = (e.st == SS_RUNNING);
               do_boost = (boost_nx >= boost_per_ff);
               if (run) begin
                  wdata.ticks = tk;
                  if (!e.level) begin
                     if (tk >= q0_ff) begin wdata.level = 1'b1; pre = 1'b1; end
                  end else if (tk >= q1_ff) begin
                     if (e.prio != 8'd0) wdata.prio = e.prio - 8'd1;
                     pre = 1'b1;
                  end
                  if (pre) begin wdata.ticks = 4'd0; wdata.st = SS_RUNNABLE; end
                  we = 1'b1;
                  rpid_c = e.pid; rlvl_c = do_boost ? 1'b0 : wdata.level;
               end else rs_c = RS_NOPID;
            end
            F_SETPRIO: begin
               if (ok_ff) begin
                  we = 1'b1; wdata.prio = cur_ff.npri;
                  rpid_c = e.pid; rlvl_c = e.level;
               end else rs_c = RS_NOPID;
            end
            F_YIELD, F_SLEEP: begin
               if (e.st == SS_RUNNING) begin
                  we = 1'b1;
                  if (cur_ff.func == F_YIELD) begin
                     wdata.ticks = 4'd0; wdata.st = SS_RUNNABLE;
                  end else begin
                     wdata.chan = cur_ff.chan; wdata.st = SS_SLEEPING;
                  end
                  rpid_c = e.pid; rlvl_c = e.level;
               end else rs_c = RS_NOPID;
            end
            F_WAKE: rs_c = RS_OK;
            default: begin
               if (e.st != SS_UNUSED) begin
                  clr_vld = 1'b1; rpid_c = e.pid;
               end else rs_c = RS_NOPID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         vld_ff       <= '0;
         sch_ff       <= '0;
         pid_ctr_ff   <= 16'd1;
         boost_cnt_ff <= 8'd0;
         cursor_ff    <= '0;
         found_ff     <= 1'b0;
         boost_per_ff <= 8'd100;
         q0_ff        <= 4'd4;
         q1_ff        <= 4'd8;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_BOOST: boost_per_ff <= csr_wdata;
               CSR_Q0:    q0_ff <= csr_wdata[3:0];
               CSR_Q1:    q1_ff <= csr_wdata[3:0];
               default:   ;
            endcase
         end
         if (clr_vld) vld_ff[tgt_ff] <= 1'b0;
         else if (we) vld_ff[waddr] <= 1'b1;
         // A boost clears every level, priority and tick count at once.
         if (fire && cur_ff.func == F_TICK && do_boost) sch_ff <= '0;
         else if (we) sch_ff[waddr] <= 1'b1;
         if (fire && cur_ff.func == F_TICK)
            boost_cnt_ff <= do_boost ? 8'd0 : boost_nx;
         if (fire && cur_ff.func == F_CREATE && ok_ff) pid_ctr_ff <= pid_ctr_ff + 16'd1;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         dv_ff <= (st_ff == B_SCAN) && (cnt_ff != CNT_W'(SLOTS));
         if (st_ff == B_IDLE) cnt_ff <= '0;
         else if (st_ff == B_SCAN && cnt_ff != CNT_W'(SLOTS)) cnt_ff <= cnt_ff + 1'b1;
         if (st_ff == B_DECIDE && cur_ff.func == F_SCHED) begin
            if (hit_ff) begin
               found_ff <= 1'b1; cursor_ff <= {1'b0, hit_idx_ff} + 1'b1;
            end else if (found_ff && any_ff) begin
               found_ff <= 1'b1; cursor_ff <= {1'b0, any_idx_ff} + 1'b1;
            end else begin
               found_ff <= 1'b0; cursor_ff <= '0;
            end
         end
      end
   end

   // Scan bookkeeping and payload registers.
   always_ff @(posedge clock) begin
      didx_ff <= cnt_ff[IDX_W-1:0];
      if (st_ff == B_IDLE) begin
         cur_ff  <= q_in.op;
         tgt_ff  <= q_in.op.slot[IDX_W-1:0];
         hit_ff  <= 1'b0;
         any_ff  <= 1'b0;
         best_ff <= 1'b0;
      end
      if (st_ff == B_SCAN && dv_ff) begin
         case (cur_ff.func)
            F_CREATE:
               if (!hit_ff && e.st == SS_UNUSED) begin
                  hit_ff <= 1'b1; hit_idx_ff <= didx_ff;
               end
            F_SETPRIO:
               if (!hit_ff && e.st != SS_UNUSED && e.pid == cur_ff.tpid) begin
                  hit_ff <= 1'b1; hit_idx_ff <= didx_ff;
               end
            F_SCHED: begin
               if (e.st == SS_RUNNABLE && !e.level) begin
                  if (!any_ff) begin any_ff <= 1'b1; any_idx_ff <= didx_ff; end
                  if (!hit_ff && {1'b0, didx_ff} >= cursor_ff) begin
                     hit_ff <= 1'b1; hit_idx_ff <= didx_ff;
                  end
               end
               if (e.st == SS_RUNNABLE && (!best_ff || e.prio > best_pri_ff ||
                   (e.prio == best_pri_ff && e.pid < best_pid_ff))) begin
                  best_ff <= 1'b1; best_idx_ff <= didx_ff;
                  best_pri_ff <= e.prio; best_pid_ff <= e.pid;
               end
            end
            default: ;
         endcase
      end
      if (st_ff == B_DECIDE) begin
         if (cur_ff.func == F_SCHED && !hit_ff) begin
            if (found_ff && any_ff) begin
               ok_ff <= 1'b1; tgt_ff <= any_idx_ff;
            end else begin
               ok_ff <= best_ff; tgt_ff <= best_idx_ff;
            end
         end else begin
            ok_ff  <= hit_ff;
            tgt_ff <= hit_idx_ff;
         end
      end
      if (fire) begin
         rs_ff    <= rs_c;
         rslot_ff <= (rs_c == RS_OK && cur_ff.func != F_WAKE) ? 6'(tgt_ff) : 6'd0;
         rpid_ff  <= rpid_c;
         rlvl_ff  <= rlvl_c;
         rpre_ff  <= pre;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rs_ff;
   assign rsp_tdata  = {rpre_ff, rlvl_ff, rpid_ff, rslot_ff};

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      st_ff == B_SCAN |-> cnt_ff <= CNT_W'(SLOTS))
      else $error("scan counter out of range");
   a_dec: assert property (@(posedge clock) disable iff (reset)
      st_ff == B_DECIDE |=> st_ff == B_READ)
      else $error("decide not followed by target read");
   a_rel: assert property (@(posedge clock) disable iff (reset)
      clr_vld |=> !vld_ff[$past(tgt_ff)])
      else $error("released slot still valid");
endmodule
`default_nettype wire

>>> rtl/mlfq_process_scheduler_unit.sv
// Top level of the two-level feedback queue scheduler.
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser func, tdata slot..channel
//  rsp     | out | rsp_tvalid/tready    | tuser status, tdata slot..preempted
//  csr     | in  | csr_we               | csr_addr index, csr_wdata value
// Create, schedule, set priority and wake sweep all 64 slots through the table
// memory's single read port. Tick, yield, sleep and release read one entry.
// Reset is synchronous and needs no clearing pass.
// A result waits in the output register; two requests queue ahead of the engine.
`default_nettype none
module mlfq_process_scheduler_unit import mlfq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // slot, target_pid, new_priority, channel, pad
   input  wire logic [2:0]  req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // chosen_slot, chosen_pid, chosen_level, preempted
   output logic [1:0]       rsp_tuser,  // status
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   qout_type q;
   logic     pop;

   mlfq_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_out(q), .q_pop(pop)
   );

   mlfq_back u_back (
      .clock, .reset, .q_in(q), .q_pop(pop), .csr_we, .csr_addr, .csr_wdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );
endmodule
`default_nettype wire
